### sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the sorted record table
// Record layout, operation and status codes, and the bundle that loads the
// response register.
// ----------------------------------------------------------------------------
package srt_pkg;

   // Operation codes carried by req_kind.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SHOW   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Status codes carried by rsp_status.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   // One stored record, as it sits in the table memory.
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] score;
      logic [63:0] name;
   } record_type;

   // One result, handed from the sequencer to the response register.
   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [31:0] id;
      logic [31:0] score;
      logic [63:0] name;
      logic [5:0]  count;
      logic        last;
   } out_load_type;

endpackage

### sv/srt_mem.sv
// ----------------------------------------------------------------------------
// srt_mem: record storage
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module srt_mem
   import srt_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  record_type    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output record_type    rd_data
);

   record_type mem_ff [DEPTH];
   record_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/srt_out.sv
// ----------------------------------------------------------------------------
// srt_out: response register
// Holds one result until the receiver takes it and tells the sequencer when
// the slot is free for the next cycle.
// ----------------------------------------------------------------------------
module srt_out
   import srt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  out_load_type       load,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_id_out,
   output logic signed [31:0] rsp_score_out,
   output logic        [63:0] rsp_name_tag_out,
   output logic        [5:0]  rsp_record_count,
   output logic               rsp_last
);

   logic         valid_ff;
   out_load_type data_ff;

   // Valid flag: set on a load, cleared when the receiver takes the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load.valid) begin
         data_ff <= load;
      end
   end

   assign out_free         = !valid_ff || rsp_ready;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = data_ff.status;
   assign rsp_id_out       = $signed(data_ff.id);
   assign rsp_score_out    = $signed(data_ff.score);
   assign rsp_name_tag_out = data_ff.name;
   assign rsp_record_count = data_ff.count;
   assign rsp_last         = data_ff.last;

endmodule

### sv/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl: table sequencer
// Walks the record memory for each request: a backward shift for insert, a
// forward search and close-up for remove, and an ordered read-out for show.
// ----------------------------------------------------------------------------
module srt_ctrl
   import srt_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int AW       = 5,
   parameter int CW       = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [1:0]  req_kind,
   input  logic signed [31:0] req_key_id,
   input  logic signed [31:0] req_score_in,
   input  logic        [63:0] req_name_tag_in,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output record_type         mem_wr_data,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  record_type         mem_rd_data,
   input  logic               out_free,
   output out_load_type       out_load
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_INS_SCAN = 6'b000010,
      S_INS_HEAD = 6'b000100,
      S_REM_SCAN = 6'b001000,
      S_SHOW     = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic           issuing_ff, issuing_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_idx_ff, pend_idx_in;
   logic           found_ff, found_in;
   logic [1:0]     status_ff, status_in;
   logic [31:0]    key_ff, key_in;
   logic [31:0]    score_ff, score_in;
   logic [63:0]    name_ff, name_in;

   logic [CW-1:0]  count_m1;
   logic [AW-1:0]  last_idx;
   logic [6:0]     count_ext;
   logic           is_full;
   logic           is_empty;
   logic           id_match;
   logic           key_below;
   record_type     new_rec;

   assign count_m1  = count_ff - CW'(1);
   assign last_idx  = count_m1[AW-1:0];
   assign count_ext = 7'(count_ff);
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign id_match  = (mem_rd_data.id == key_ff);
   assign key_below = ($signed(key_ff) < $signed(mem_rd_data.id));
   assign new_rec   = '{id: key_ff, score: score_ff, name: name_ff};
   assign req_ready = (state_ff == S_IDLE);

   // Next-state and datapath control.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      issuing_in  = issuing_ff;
      pend_in     = 1'b0;
      pend_idx_in = rd_idx_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      key_in      = key_ff;
      score_in    = score_ff;
      name_in     = name_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = new_rec;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_idx_ff;
      out_load    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_key_id;
               score_in = req_score_in;
               name_in  = req_name_tag_in;
               unique case (req_kind)
                  KIND_INSERT: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                        state_in  = S_RESP;
                     end else if (is_empty) begin
                        state_in = S_INS_HEAD;
                     end else begin
                        rd_idx_in  = last_idx;
                        issuing_in = 1'b1;
                        state_in   = S_INS_SCAN;
                     end
                  end
                  KIND_REMOVE: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        rd_idx_in  = '0;
                        issuing_in = 1'b1;
                        found_in   = 1'b0;
                        state_in   = S_REM_SCAN;
                     end
                  end
                  KIND_SHOW: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        rd_idx_in  = '0;
                        issuing_in = 1'b1;
                        state_in   = S_SHOW;
                     end
                  end
                  default: begin
                     // The unused code is taken and dropped without a result.
                  end
               endcase
            end
         end

         S_INS_SCAN: begin
            // Read from the tail toward the head, one entry per cycle.
            mem_rd_en = issuing_ff;
            pend_in   = issuing_ff;
            if (issuing_ff) begin
               if (rd_idx_ff == '0) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff - AW'(1);
               end
            end
            // Each returning entry with a larger id moves up one slot; the
            // first one that does not marks where the new record goes.
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_idx_ff + AW'(1);
               if (key_below) begin
                  mem_wr_data = mem_rd_data;
                  if (pend_idx_ff == '0) begin
                     state_in = S_INS_HEAD;
                  end
               end else begin
                  mem_wr_data = new_rec;
                  count_in    = count_ff + CW'(1);
                  status_in   = STAT_OK;
                  issuing_in  = 1'b0;
                  pend_in     = 1'b0;
                  state_in    = S_RESP;
               end
            end
         end

         S_INS_HEAD: begin
            // Every stored id is larger, or the table was empty.
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = new_rec;
            count_in    = count_ff + CW'(1);
            status_in   = STAT_OK;
            state_in    = S_RESP;
         end

         S_REM_SCAN: begin
            // Read from the head toward the tail, one entry per cycle.
            mem_rd_en = issuing_ff;
            pend_in   = issuing_ff;
            if (issuing_ff) begin
               if (rd_idx_ff == last_idx) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
            // After the first match, each later entry moves down one slot.
            if (pend_ff) begin
               if (found_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pend_idx_ff - AW'(1);
                  mem_wr_data = mem_rd_data;
               end else if (id_match) begin
                  found_in = 1'b1;
               end
               if (pend_idx_ff == last_idx) begin
                  state_in = S_RESP;
                  if (found_ff || id_match) begin
                     count_in  = count_m1;
                     status_in = STAT_OK;
                  end else begin
                     status_in = STAT_NOTFOUND;
                  end
               end
            end
         end

         S_SHOW: begin
            // A read goes out only when the response slot will be free for it.
            mem_rd_en = issuing_ff && !pend_ff && out_free;
            pend_in   = mem_rd_en;
            if (mem_rd_en) begin
               if (rd_idx_ff == last_idx) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
            if (pend_ff) begin
               out_load.valid  = 1'b1;
               out_load.status = STAT_OK;
               out_load.id     = mem_rd_data.id;
               out_load.score  = mem_rd_data.score;
               out_load.name   = mem_rd_data.name;
               out_load.count  = count_ext[5:0];
               out_load.last   = (pend_idx_ff == last_idx);
               if (pend_idx_ff == last_idx) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            // Single status result once the response slot frees up.
            if (out_free) begin
               out_load.valid  = 1'b1;
               out_load.status = status_ff;
               out_load.count  = count_ext[5:0];
               out_load.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         issuing_ff <= 1'b0;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         issuing_ff <= issuing_in;
         pend_ff    <= pend_in;
         found_ff   <= found_in;
      end
   end

   // Working registers need no reset.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      status_ff   <= status_in;
      key_ff      <= key_in;
      score_ff    <= score_in;
      name_ff     <= name_in;
   end

endmodule

### sv/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table: table of records kept in ascending signed id order
// Top level joining the sequencer, the record memory and the response register.
// ----------------------------------------------------------------------------
// Usage:
// A request on the req_ channel is an insert, a remove by id or a show. Insert
// places the record after all stored records with id less than or equal to
// its own; remove deletes the first record with the given id. Both answer with
// one status response. Show answers with one response per stored record in
// id order, the final one flagged by rsp_last, or one empty-status response.
// A request with the unused kind code is taken and produces no response.
// Requests are taken one at a time: req_ready is high only while the block
// is idle, though a finished response may still wait in the output register.
// An insert reads from the tail and moves each record with a larger id up one
// slot; a remove reads every stored record from the head; both are limited by
// the single read port of the record memory. A show reads a record only once
// the previous one is loaded into the response register and while the response
// slot is free. Reset empties the table; no memory sweep is needed since only
// entries below the record count are ever read. When the receiver stalls, the
// response holds on the rsp_ ports and the sequencer waits.
// ----------------------------------------------------------------------------
module sorted_record_table
   import srt_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [1:0]  req_kind,
   input  logic signed [31:0] req_key_id,
   input  logic signed [31:0] req_score_in,
   input  logic        [63:0] req_name_tag_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_id_out,
   output logic signed [31:0] rsp_score_out,
   output logic        [63:0] rsp_name_tag_out,
   output logic        [5:0]  rsp_record_count,
   output logic               rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   record_type    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   record_type    mem_rd_data;
   logic          out_free;
   out_load_type  out_load;

   // Request sequencer.
   srt_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key_id      (req_key_id),
      .req_score_in    (req_score_in),
      .req_name_tag_in (req_name_tag_in),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .out_free        (out_free),
      .out_load        (out_load)
   );

   // Record memory.
   srt_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response register.
   srt_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_id_out       (rsp_id_out),
      .rsp_score_out    (rsp_score_out),
      .rsp_name_tag_out (rsp_name_tag_out),
      .rsp_record_count (rsp_record_count),
      .rsp_last         (rsp_last)
   );

endmodule

### sv/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_port_checks: port-level checks for the sorted record table
// Watches the response channel and is bound to every instance of the table.
// ----------------------------------------------------------------------------
module srt_port_checks
   import srt_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic        [1:0]  rsp_status,
   input logic signed [31:0] rsp_id_out,
   input logic signed [31:0] rsp_score_out,
   input logic        [63:0] rsp_name_tag_out,
   input logic        [5:0]  rsp_record_count,
   input logic               rsp_last
);

   localparam logic [6:0] CAP_MASKED = 7'(CAPACITY % 64);

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id_out)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   // Status-only responses carry no record and end the request.
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last && rsp_id_out == 0
         && rsp_score_out == 0 && rsp_name_tag_out == '0)
      else $error("status response carries record data");

   // Only show records continue past one response.
   a_more_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STAT_OK)
      else $error("non-final response with error status");

   // An empty status means nothing is stored.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_record_count == 6'd0)
      else $error("empty status with nonzero count");

   // The count never passes the capacity; checked only for a capacity below 64.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && CAPACITY < 64 |-> 7'(rsp_record_count) <= CAP_MASKED)
      else $error("record count beyond capacity");

endmodule

bind sorted_record_table srt_port_checks #(.CAPACITY(CAPACITY)) u_port_checks (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_id_out       (rsp_id_out),
   .rsp_score_out    (rsp_score_out),
   .rsp_name_tag_out (rsp_name_tag_out),
   .rsp_record_count (rsp_record_count),
   .rsp_last         (rsp_last)
);
